// ===== design/wbfe_pkg.sv =====
// wbfe_pkg: shared types and constants for the ws2812 blink frame encoder
// used by the led table, the slot emitter and the top level
// no dependencies
`default_nettype none

package wbfe_pkg;

  localparam int NUM_LEDS  = 16;
  localparam int LED_IDX_W = 4;
  localparam int WORD_W    = 24;
  localparam int BIT_CNT_W = 5;
  localparam int PADDR_W   = 4;

  // request codes
  localparam logic [2:0] REQ_COLOUR = 3'd0;
  localparam logic [2:0] REQ_BLINK  = 3'd1;
  localparam logic [2:0] REQ_STEADY = 3'd2;
  localparam logic [2:0] REQ_MODE   = 3'd3;
  localparam logic [2:0] REQ_TICK   = 3'd4;
  localparam logic [2:0] REQ_RENDER = 3'd5;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_ONE_HIGH  = 2'd0;
  localparam logic [1:0] REG_ZERO_HIGH = 2'd1;
  localparam logic [1:0] REG_PREAMBLE  = 2'd2;
  localparam logic [1:0] REG_LATCH     = 2'd3;

  // register reset values
  localparam logic [7:0] ONE_HIGH_RST  = 8'd58;
  localparam logic [7:0] ZERO_HIGH_RST = 8'd29;
  localparam logic [9:0] PREAMBLE_RST  = 10'd16;
  localparam logic [9:0] LATCH_RST     = 10'd100;

  typedef struct packed {
    logic [2:0]           req_type;
    logic [LED_IDX_W-1:0] led_index;
    logic [7:0]           red;
    logic [7:0]           green;
    logic [7:0]           blue;
    logic [15:0]          blink_on_time;
    logic signed [7:0]    blink_repeats;
    logic                 steady_level;
    logic                 mode_value;
    logic                 first_led;
    logic                 last_led;
  } wbfe_item_t;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              first_led;
    logic              last_led;
  } wbfe_job_t;

  typedef struct packed {
    logic [7:0] one_high_ticks;
    logic [7:0] zero_high_ticks;
    logic [9:0] preamble_slots;
    logic [9:0] latch_slots;
  } wbfe_cfg_t;

endpackage

`default_nettype wire

// ===== design/wbfe_led_table.sv =====
// wbfe_led_table: per-led colour and blink state, millisecond clock, blink step
// produces the gated grb word for render items
// depends on wbfe_pkg
`default_nettype none

module wbfe_led_table (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_take,
  input  wire wbfe_pkg::wbfe_item_t item,
  output logic                   job_valid,
  output wbfe_pkg::wbfe_job_t    job
);

  logic [31:0]                  ms_now;
  logic [wbfe_pkg::WORD_W-1:0]  led_colour         [wbfe_pkg::NUM_LEDS];
  logic [15:0]                  led_on_time        [wbfe_pkg::NUM_LEDS];
  logic [7:0]                   led_repeat_setting [wbfe_pkg::NUM_LEDS];
  logic                         led_steady_level   [wbfe_pkg::NUM_LEDS];
  logic                         led_mode           [wbfe_pkg::NUM_LEDS];
  logic                         led_blink_level    [wbfe_pkg::NUM_LEDS];
  logic [8:0]                   led_toggles_left   [wbfe_pkg::NUM_LEDS];
  logic [31:0]                  led_start_stamp    [wbfe_pkg::NUM_LEDS];

  logic [wbfe_pkg::LED_IDX_W-1:0] idx;
  logic        idx_ok;
  logic [31:0] elapsed;
  logic        due;
  logic        tog_pos;
  logic        tog_end;
  logic [8:0]  tog_dec;
  logic        lvl;

  assign idx     = item.led_index;
  assign idx_ok  = int'(item.led_index) < wbfe_pkg::NUM_LEDS;
  assign elapsed = ms_now - led_start_stamp[idx];
  assign due     = elapsed >= {16'd0, led_on_time[idx]};
  assign tog_pos = !led_toggles_left[idx][8] && (led_toggles_left[idx] != 9'd0);
  assign tog_dec = led_toggles_left[idx] - 9'd1;
  assign tog_end = tog_pos && (led_toggles_left[idx] == 9'd1);

  // level after the blink step
  always_comb begin
    if (!led_mode[idx]) begin
      lvl = led_steady_level[idx];
    end else if (!due) begin
      lvl = led_blink_level[idx];
    end else if (tog_end) begin
      lvl = led_steady_level[idx];
    end else begin
      lvl = !led_blink_level[idx];
    end
  end

  assign job_valid = item_take && (item.req_type == wbfe_pkg::REQ_RENDER) && idx_ok;
  assign job       = '{word:      lvl ? led_colour[idx] : '0,
                       first_led: item.first_led,
                       last_led:  item.last_led};

  always_ff @(posedge clk) begin
    if (rst) begin
      ms_now <= '0;
      for (int i = 0; i < wbfe_pkg::NUM_LEDS; i++) begin
        led_colour[i]         <= '0;
        led_on_time[i]        <= '0;
        led_repeat_setting[i] <= '0;
        led_steady_level[i]   <= 1'b0;
        led_mode[i]           <= 1'b0;
        led_blink_level[i]    <= 1'b0;
        led_toggles_left[i]   <= '0;
        led_start_stamp[i]    <= '0;
      end
    end else if (item_take) begin
      unique case (item.req_type)
        wbfe_pkg::REQ_TICK: begin
          ms_now <= ms_now + 32'd1;
        end
        wbfe_pkg::REQ_COLOUR: begin
          if (idx_ok) begin
            led_colour[idx] <= {item.green, item.red, item.blue};
          end
        end
        wbfe_pkg::REQ_BLINK: begin
          if (idx_ok) begin
            led_on_time[idx]        <= item.blink_on_time;
            led_repeat_setting[idx] <= item.blink_repeats;
          end
        end
        wbfe_pkg::REQ_STEADY: begin
          if (idx_ok) begin
            led_steady_level[idx] <= item.steady_level;
          end
        end
        wbfe_pkg::REQ_MODE: begin
          if (idx_ok) begin
            // steady to blink starts a fresh blink sequence
            if (!led_mode[idx] && item.mode_value) begin
              led_blink_level[idx]  <= !led_steady_level[idx];
              led_toggles_left[idx] <= {led_repeat_setting[idx], 1'b0};
              led_start_stamp[idx]  <= ms_now;
            end
            led_mode[idx] <= item.mode_value;
          end
        end
        wbfe_pkg::REQ_RENDER: begin
          if (idx_ok && led_mode[idx] && due) begin
            led_start_stamp[idx] <= ms_now;
            if (tog_pos) begin
              led_toggles_left[idx] <= tog_dec;
            end
            if (tog_end) begin
              led_mode[idx]        <= 1'b0;
              led_blink_level[idx] <= led_steady_level[idx];
            end else begin
              led_blink_level[idx] <= !led_blink_level[idx];
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/wbfe_slot_emitter.sv =====
// wbfe_slot_emitter: turns one grb word into preamble, bit and latch runs
// holds the result register toward the output channel
// depends on wbfe_pkg
`default_nettype none

module wbfe_slot_emitter (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                job_load,
  input  wire wbfe_pkg::wbfe_job_t job,
  input  wire wbfe_pkg::wbfe_cfg_t cfg,
  output logic                     idle,
  input  wire logic                out_ready,
  output logic                     out_valid,
  output logic [7:0]               slot_duty,
  output logic [9:0]               slot_repeat,
  output logic                     run_last
);

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_PRE   = 2'd1;
  localparam logic [1:0] PH_BITS  = 2'd2;
  localparam logic [1:0] PH_LATCH = 2'd3;

  logic [1:0]                     phase;
  logic [wbfe_pkg::WORD_W-1:0]    word;
  logic [wbfe_pkg::BIT_CNT_W-1:0] bit_cnt;
  logic                           latch_en;
  logic                           emit;

  assign idle = (phase == PH_IDLE);
  assign emit = !idle && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (job_load) begin
        word     <= job.word;
        latch_en <= job.last_led && (cfg.latch_slots != 10'd0);
        bit_cnt  <= wbfe_pkg::BIT_CNT_W'(wbfe_pkg::WORD_W - 1);
        phase    <= (job.first_led && (cfg.preamble_slots != 10'd0)) ? PH_PRE : PH_BITS;
      end else if (emit) begin
        out_valid <= 1'b1;
        unique case (phase)
          PH_PRE: begin
            slot_duty   <= 8'd0;
            slot_repeat <= cfg.preamble_slots;
            run_last    <= 1'b0;
            phase       <= PH_BITS;
          end
          PH_BITS: begin
            slot_duty   <= word[wbfe_pkg::WORD_W-1] ? cfg.one_high_ticks
                                                    : cfg.zero_high_ticks;
            slot_repeat <= 10'd1;
            run_last    <= (bit_cnt == '0) && !latch_en;
            word        <= word << 1;
            bit_cnt     <= bit_cnt - 1'b1;
            if (bit_cnt == '0) begin
              phase <= latch_en ? PH_LATCH : PH_IDLE;
            end
          end
          PH_LATCH: begin
            slot_duty   <= 8'd0;
            slot_repeat <= cfg.latch_slots;
            run_last    <= 1'b1;
            phase       <= PH_IDLE;
          end
          default: begin
            phase <= PH_IDLE;
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/ws2812_blink_frame_encoder_top.sv =====
// ws2812_blink_frame_encoder_top: top level of the ws2812 blink frame encoder
// apb register file, input holding register, led table and slot emitter
// depends on wbfe_pkg, wbfe_led_table, wbfe_slot_emitter
// input channel (in_valid/in_ready): one request per transfer. colour, blink
//   settings, steady level and mode requests update the addressed led, a tick
//   request advances the millisecond clock, a render request runs the led's
//   blink step and produces its slot runs
// output channel (out_valid/out_ready): one run per transfer. a render gives an
//   optional preamble run (first_led), 24 single-slot bit runs msb first in grb
//   order and an optional latch run (last_led); run_last marks its final run
// apb port: one high ticks, zero high ticks, preamble slots, latch slots at
//   byte addresses 0, 4, 8, 12; pready is always high
// timing: a request is captured in the holding register and applied to the led
//   table from there, so non-render requests go one per cycle. with the emitter
//   idle a render passes the holding register and the emitter's load before its
//   first run reaches the output register, then one run per cycle while out_ready
//   is high; the next render is loaded only once the emitter has gone idle
// reset clears the led table and clock, restores register defaults and drops
//   out_valid. a stalled receiver holds the run in the output register, the
//   emitter waits and in_ready falls while a render is held behind it
`default_nettype none

module ws2812_blink_frame_encoder_top (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // apb configuration port
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [wbfe_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                  pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  // request channel
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [2:0]                   req_type,
  input  wire logic [3:0]                   led_index,
  input  wire logic [7:0]                   red,
  input  wire logic [7:0]                   green,
  input  wire logic [7:0]                   blue,
  input  wire logic [15:0]                  blink_on_time,
  input  wire logic signed [7:0]            blink_repeats,
  input  wire logic                         steady_level,
  input  wire logic                         mode_value,
  input  wire logic                         first_led,
  input  wire logic                         last_led,
  // run channel
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [7:0]                        slot_duty,
  output logic [9:0]                        slot_repeat,
  output logic                              run_last
);

  wbfe_pkg::wbfe_cfg_t  cfg;
  wbfe_pkg::wbfe_item_t item_q;
  wbfe_pkg::wbfe_job_t  job;
  logic                 hold_valid;
  logic                 consume;
  logic                 job_valid;
  logic                 emit_idle;
  logic                 cfg_write;
  logic [1:0]           reg_sel;

  // apb register file
  assign pready    = 1'b1;
  assign reg_sel   = paddr[3:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.one_high_ticks  <= wbfe_pkg::ONE_HIGH_RST;
      cfg.zero_high_ticks <= wbfe_pkg::ZERO_HIGH_RST;
      cfg.preamble_slots  <= wbfe_pkg::PREAMBLE_RST;
      cfg.latch_slots     <= wbfe_pkg::LATCH_RST;
    end else if (cfg_write) begin
      unique case (reg_sel)
        wbfe_pkg::REG_ONE_HIGH:  cfg.one_high_ticks  <= pwdata[7:0];
        wbfe_pkg::REG_ZERO_HIGH: cfg.zero_high_ticks <= pwdata[7:0];
        wbfe_pkg::REG_PREAMBLE:  cfg.preamble_slots  <= pwdata[9:0];
        wbfe_pkg::REG_LATCH:     cfg.latch_slots     <= pwdata[9:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      wbfe_pkg::REG_ONE_HIGH:  prdata = {24'd0, cfg.one_high_ticks};
      wbfe_pkg::REG_ZERO_HIGH: prdata = {24'd0, cfg.zero_high_ticks};
      wbfe_pkg::REG_PREAMBLE:  prdata = {22'd0, cfg.preamble_slots};
      wbfe_pkg::REG_LATCH:     prdata = {22'd0, cfg.latch_slots};
      default:                 prdata = '0;
    endcase
  end

  // holding register: a render waits here until the emitter is idle
  assign consume  = hold_valid &&
                    ((item_q.req_type != wbfe_pkg::REQ_RENDER) || emit_idle);
  assign in_ready = !hold_valid || consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        hold_valid <= 1'b1;
      end else if (consume) begin
        hold_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_q.req_type      <= req_type;
      item_q.led_index     <= led_index;
      item_q.red           <= red;
      item_q.green         <= green;
      item_q.blue          <= blue;
      item_q.blink_on_time <= blink_on_time;
      item_q.blink_repeats <= blink_repeats;
      item_q.steady_level  <= steady_level;
      item_q.mode_value    <= mode_value;
      item_q.first_led     <= first_led;
      item_q.last_led      <= last_led;
    end
  end

  wbfe_led_table u_led_table (
    .clk       (clk),
    .rst       (rst),
    .item_take (consume),
    .item      (item_q),
    .job_valid (job_valid),
    .job       (job)
  );

  wbfe_slot_emitter u_slot_emitter (
    .clk         (clk),
    .rst         (rst),
    .job_load    (job_valid),
    .job         (job),
    .cfg         (cfg),
    .idle        (emit_idle),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .slot_duty   (slot_duty),
    .slot_repeat (slot_repeat),
    .run_last    (run_last)
  );

endmodule

`default_nettype wire

// ===== design/wbfe_checker.sv =====
// wbfe_port_checker: port-level checks on the ws2812 blink frame encoder
// bound to ws2812_blink_frame_encoder_top; no other dependencies
`default_nettype none

module wbfe_port_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] slot_duty,
  input wire logic [9:0] slot_repeat,
  input wire logic       run_last
);

  // a stalled run holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(slot_duty) &&
                                   $stable(slot_repeat) && $stable(run_last)))
    else $error("stalled run changed");

  // no run is empty
  a_repeat_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (slot_repeat != 10'd0))
    else $error("run with zero slots");

  // multi-slot runs are preamble or latch, always low
  a_long_run_low: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (slot_repeat != 10'd1)) |-> (slot_duty == 8'd0))
    else $error("long run with nonzero duty");

  // reset empties the output register
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind ws2812_blink_frame_encoder_top wbfe_port_checker u_wbfe_port_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .slot_duty   (slot_duty),
  .slot_repeat (slot_repeat),
  .run_last    (run_last)
);

`default_nettype wire

// ===== verif/wbfe_checker.sv =====
// wbfe_checker: watches the request, run and apb channels of the ws2812 blink frame encoder,
// predicts the slot runs of every render and compares them with what leaves the block
// depends on wbfe_pkg
`timescale 1ns / 100ps

module wbfe_checker (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic                         pready,
  input  wire logic [wbfe_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                  pwdata,
  input  wire logic                         in_valid,
  input  wire logic                         in_ready,
  input  wire logic [2:0]                   req_type,
  input  wire logic [3:0]                   led_index,
  input  wire logic [7:0]                   red,
  input  wire logic [7:0]                   green,
  input  wire logic [7:0]                   blue,
  input  wire logic [15:0]                  blink_on_time,
  input  wire logic signed [7:0]            blink_repeats,
  input  wire logic                         steady_level,
  input  wire logic                         mode_value,
  input  wire logic                         first_led,
  input  wire logic                         last_led,
  input  wire logic                         out_valid,
  input  wire logic                         out_ready,
  input  wire logic [7:0]                   slot_duty,
  input  wire logic [9:0]                   slot_repeat,
  input  wire logic                         run_last,
  output int                                fail_count,
  output int                                runs_pending
);
  import wbfe_pkg::*;

  typedef struct packed {
    logic [7:0] duty;
    logic [9:0] count;
    logic       last;
  } slot_run_t;

  slot_run_t pending_runs[$];

  // register copy
  logic [7:0] one_ticks, zero_ticks;
  logic [9:0] pre_len, latch_len;

  // led table copy
  logic [31:0]       ms_clock;
  logic [23:0]       grb_colour[NUM_LEDS];
  logic [15:0]       on_period[NUM_LEDS];
  logic signed [7:0] rep_set[NUM_LEDS];
  logic              steady_on[NUM_LEDS];
  logic              blinking[NUM_LEDS];
  logic              blink_on[NUM_LEDS];
  logic signed [8:0] toggles_left[NUM_LEDS];
  logic [31:0]       toggle_stamp[NUM_LEDS];

  initial begin
    fail_count   = 0;
    runs_pending = 0;
  end

  task automatic report_mismatch(input string what, input int want, input int got);
    $display("%0t: mismatch in %s: expected %0d, got %0d", $realtime, what, want, got);
    fail_count++;
  endtask

  task automatic clear_model();
    one_ticks  = ONE_HIGH_RST;
    zero_ticks = ZERO_HIGH_RST;
    pre_len    = PREAMBLE_RST;
    latch_len  = LATCH_RST;
    ms_clock   = '0;
    for (int i = 0; i < NUM_LEDS; i++) begin
      grb_colour[i]   = '0;
      on_period[i]    = '0;
      rep_set[i]      = '0;
      steady_on[i]    = 1'b0;
      blinking[i]     = 1'b0;
      blink_on[i]     = 1'b0;
      toggles_left[i] = '0;
      toggle_stamp[i] = '0;
    end
    pending_runs.delete();
  endtask

  // blink step of one led, then queue its gated grb word as slot runs
  task automatic predict_render(input int idx, input logic first, input logic last);
    logic       lit;
    logic [23:0] word;
    logic       has_latch;
    slot_run_t  run;
    if (!blinking[idx]) begin
      lit = steady_on[idx];
    end else begin
      if ((ms_clock - toggle_stamp[idx]) >= {16'd0, on_period[idx]}) begin
        toggle_stamp[idx] = ms_clock;
        blink_on[idx]     = ~blink_on[idx];
        if (toggles_left[idx] > 0) begin
          toggles_left[idx] = toggles_left[idx] - 9'sd1;
          if (toggles_left[idx] == 0) begin
            blinking[idx] = 1'b0;
            blink_on[idx] = steady_on[idx];
          end
        end
      end
      lit = blink_on[idx];
    end
    word      = lit ? grb_colour[idx] : 24'd0;
    has_latch = last && (latch_len != 0);
    if (first && pre_len != 0) begin
      run = '{duty: 8'd0, count: pre_len, last: 1'b0};
      pending_runs.push_back(run);
    end
    for (int b = 23; b >= 0; b--) begin
      run = '{duty: word[b] ? one_ticks : zero_ticks, count: 10'd1,
              last: (b == 0) && !has_latch};
      pending_runs.push_back(run);
    end
    if (has_latch) begin
      run = '{duty: 8'd0, count: latch_len, last: 1'b1};
      pending_runs.push_back(run);
    end
  endtask

  task automatic predict_request();
    int idx;
    idx = int'(led_index);
    case (req_type)
      REQ_COLOUR: grb_colour[idx] = {green, red, blue};
      REQ_BLINK: begin
        on_period[idx] = blink_on_time;
        rep_set[idx]   = blink_repeats;
      end
      REQ_STEADY: steady_on[idx] = steady_level;
      REQ_MODE: begin
        // steady to blink starts from the inverted steady level
        if (!blinking[idx] && mode_value) begin
          blink_on[idx]     = ~steady_on[idx];
          toggles_left[idx] = {rep_set[idx][7], rep_set[idx]} <<< 1;
          toggle_stamp[idx] = ms_clock;
        end
        blinking[idx] = mode_value;
      end
      REQ_TICK:   ms_clock = ms_clock + 32'd1;
      REQ_RENDER: predict_render(idx, first_led, last_led);
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_model();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_ONE_HIGH:  one_ticks  = pwdata[7:0];
          REG_ZERO_HIGH: zero_ticks = pwdata[7:0];
          REG_PREAMBLE:  pre_len    = pwdata[9:0];
          REG_LATCH:     latch_len  = pwdata[9:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        predict_request();
      end
      if (out_valid && out_ready) begin
        if (pending_runs.size() == 0) begin
          report_mismatch("unexpected run, duty", -1, int'(slot_duty));
        end else begin
          slot_run_t want;
          want = pending_runs.pop_front();
          if (slot_duty !== want.duty) begin
            report_mismatch("slot_duty", int'(want.duty), int'(slot_duty));
          end
          if (slot_repeat !== want.count) begin
            report_mismatch("slot_repeat", int'(want.count), int'(slot_repeat));
          end
          if (run_last !== want.last) begin
            report_mismatch("run_last", int'(want.last), int'(run_last));
          end
        end
      end
    end
    runs_pending = pending_runs.size();
  end

endmodule

// ===== verif/tb_top.sv =====
// tb_top: stimulus and verdict for the ws2812 blink frame encoder
// drives requests and apb writes, stalls the run channel, and relies on wbfe_checker
// depends on wbfe_pkg, wbfe_checker, ws2812_blink_frame_encoder_top
`timescale 1ns / 100ps

module tb_top;
  import wbfe_pkg::*;

  // request codes the block must ignore
  localparam logic [2:0] REQ_SPARE_6 = 3'd6;
  localparam logic [2:0] REQ_SPARE_7 = 3'd7;

  // apb byte addresses of the registers
  localparam logic [PADDR_W-1:0] ADDR_ONE_HIGH  = {REG_ONE_HIGH, 2'b00};
  localparam logic [PADDR_W-1:0] ADDR_ZERO_HIGH = {REG_ZERO_HIGH, 2'b00};
  localparam logic [PADDR_W-1:0] ADDR_PREAMBLE  = {REG_PREAMBLE, 2'b00};
  localparam logic [PADDR_W-1:0] ADDR_LATCH     = {REG_LATCH, 2'b00};

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0]        pwdata = '0;
  wire  [31:0]        prdata;
  wire                pready;

  logic       in_valid = 1'b0;
  wire        in_ready;
  wbfe_item_t req_item = '0;

  wire        out_valid;
  logic       out_ready = 1'b0;
  wire  [7:0] slot_duty;
  wire  [9:0] slot_repeat;
  wire        run_last;

  int fail_count;
  int runs_pending;

  // quiet stretches: when set, that side does not idle at all
  logic calm_in = 1'b0;
  logic calm_out = 1'b0;

  always #5 clk = ~clk;

  ws2812_blink_frame_encoder_top dut (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .req_type      (req_item.req_type),
    .led_index     (req_item.led_index),
    .red           (req_item.red),
    .green         (req_item.green),
    .blue          (req_item.blue),
    .blink_on_time (req_item.blink_on_time),
    .blink_repeats (req_item.blink_repeats),
    .steady_level  (req_item.steady_level),
    .mode_value    (req_item.mode_value),
    .first_led     (req_item.first_led),
    .last_led      (req_item.last_led),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .slot_duty     (slot_duty),
    .slot_repeat   (slot_repeat),
    .run_last      (run_last)
  );

  wbfe_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .req_type      (req_item.req_type),
    .led_index     (req_item.led_index),
    .red           (req_item.red),
    .green         (req_item.green),
    .blue          (req_item.blue),
    .blink_on_time (req_item.blink_on_time),
    .blink_repeats (req_item.blink_repeats),
    .steady_level  (req_item.steady_level),
    .mode_value    (req_item.mode_value),
    .first_led     (req_item.first_led),
    .last_led      (req_item.last_led),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .slot_duty     (slot_duty),
    .slot_repeat   (slot_repeat),
    .run_last      (run_last),
    .fail_count    (fail_count),
    .runs_pending  (runs_pending)
  );

  // watchdog: if the test is still running at this delay, it reports a failure and stops
  initial begin
    #10ms;
    $display("== FAIL ==");
    $finish;
  end

  // flip each side between idling and quiet stretches now and then
  initial begin
    forever begin
      repeat ($urandom_range(60, 300)) @(negedge clk);
      calm_in  = ($urandom_range(0, 3) == 0);
      calm_out = ($urandom_range(0, 3) == 0);
    end
  end

  // run channel receiver: a random stall before each transfer, none while calm_out is set
  initial begin
    int stall;
    forever begin
      stall = calm_out ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // every unused field carries random bits so the block must ignore them
  function automatic wbfe_item_t noise_item(input logic [2:0] kind, input logic [3:0] idx);
    logic [63:0] noise;
    wbfe_item_t  it;
    noise            = {$urandom, $urandom};
    it               = noise[$bits(wbfe_item_t)-1:0];
    it.req_type      = kind;
    it.led_index     = idx;
    return it;
  endfunction

  // one transfer on the request channel; returns at the falling edge after acceptance
  // with valid still high, so back-to-back items keep valid up
  task automatic send(input wbfe_item_t it);
    int gap;
    gap = calm_in ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_item = it;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_colour(input logic [3:0] idx, input logic [7:0] g, input logic [7:0] r,
                             input logic [7:0] b);
    wbfe_item_t it;
    it       = noise_item(REQ_COLOUR, idx);
    it.green = g;
    it.red   = r;
    it.blue  = b;
    send(it);
  endtask

  task automatic send_blink(input logic [3:0] idx, input logic [15:0] period,
                            input logic signed [7:0] reps);
    wbfe_item_t it;
    it               = noise_item(REQ_BLINK, idx);
    it.blink_on_time = period;
    it.blink_repeats = reps;
    send(it);
  endtask

  task automatic send_steady(input logic [3:0] idx, input logic lvl);
    wbfe_item_t it;
    it              = noise_item(REQ_STEADY, idx);
    it.steady_level = lvl;
    send(it);
  endtask

  task automatic send_mode(input logic [3:0] idx, input logic blink);
    wbfe_item_t it;
    it            = noise_item(REQ_MODE, idx);
    it.mode_value = blink;
    send(it);
  endtask

  task automatic send_render(input logic [3:0] idx, input logic first, input logic last);
    wbfe_item_t it;
    it           = noise_item(REQ_RENDER, idx);
    it.first_led = first;
    it.last_led  = last;
    send(it);
  endtask

  // drain every expected run, then give the holding register and table time to settle
  task automatic drain();
    in_valid = 1'b0;
    while (runs_pending != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  // setup cycle, then access cycle; the register takes the value at the access edge
  task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic set_timing(input logic [7:0] one_t, input logic [7:0] zero_t,
                            input logic [9:0] pre, input logic [9:0] latch);
    drain();
    // upper bits of the one high write random: the block keeps only the register width
    apb_write(ADDR_ONE_HIGH, {24'($urandom), one_t});
    apb_write(ADDR_ZERO_HIGH, {24'd0, zero_t});
    apb_write(ADDR_PREAMBLE, {22'd0, pre});
    apb_write(ADDR_LATCH, {22'd0, latch});
  endtask

  // mostly a handful of leds so blink sequences run deep, sometimes any led
  function automatic logic [3:0] pick_led();
    return ($urandom_range(0, 9) < 7) ? 4'($urandom_range(0, 3)) : 4'($urandom_range(0, 15));
  endfunction

  task automatic random_items(input int count);
    int roll;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 30) begin
        send_render(pick_led(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end else if (roll < 50) begin
        send(noise_item(REQ_TICK, 4'($urandom_range(0, 15))));
      end else if (roll < 62) begin
        send_colour(pick_led(), 8'($urandom), 8'($urandom), 8'($urandom));
      end else if (roll < 72) begin
        // short periods and few repeats so toggles and returns to steady happen
        if ($urandom_range(0, 4) != 0) begin
          send_blink(pick_led(), 16'($urandom_range(0, 4)),
                     8'($signed($urandom_range(0, 5)) - 2));
        end else begin
          send_blink(pick_led(), 16'($urandom), 8'($urandom));
        end
      end else if (roll < 80) begin
        send_steady(pick_led(), 1'($urandom_range(0, 1)));
      end else if (roll < 93) begin
        send_mode(pick_led(), ($urandom_range(0, 3) != 0));
      end else if (roll < 97) begin
        send(noise_item($urandom_range(0, 1) ? REQ_SPARE_6 : REQ_SPARE_7, 4'($urandom)));
      end else begin
        // sender holds off until the block has delivered everything
        drain();
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed part at reset timing
    send_render(4'd3, 1'b1, 1'b1);                  // untouched led renders all zero
    send_colour(4'd0, 8'hff, 8'h00, 8'haa);
    send_steady(4'd0, 1'b1);
    send_render(4'd0, 1'b1, 1'b0);
    send_colour(4'd15, 8'h00, 8'hff, 8'h55);
    send_steady(4'd15, 1'b1);
    send_render(4'd15, 1'b0, 1'b1);
    // steady to blink with one repeat: two blink steps, the second one back to steady
    send_blink(4'd0, 16'd0, 8'sd1);
    send_mode(4'd0, 1'b1);
    send_render(4'd0, 1'b0, 1'b0);
    send_render(4'd0, 1'b0, 1'b0);
    send_render(4'd0, 1'b0, 1'b0);
    // blink forever with a period of two ticks
    send_blink(4'd15, 16'd2, -8'sd128);
    send_mode(4'd15, 1'b1);
    send_render(4'd15, 1'b1, 1'b0);
    send(noise_item(REQ_TICK, 4'd0));
    send(noise_item(REQ_TICK, 4'd15));
    send_render(4'd15, 1'b0, 1'b0);
    send_mode(4'd15, 1'b1);                          // blink to blink keeps state
    send_render(4'd15, 1'b0, 1'b1);
    send_mode(4'd15, 1'b0);                          // blink to steady
    send_render(4'd15, 1'b1, 1'b1);
    send_colour(4'd1, 8'h5a, 8'ha5, 8'hff);
    send_blink(4'd1, 16'hffff, 8'sd127);
    send_mode(4'd1, 1'b1);
    send_render(4'd1, 1'b1, 1'b1);
    send(noise_item(REQ_SPARE_6, 4'd1));
    send(noise_item(REQ_SPARE_7, 4'd0));

    // timing extremes, then random settings
    set_timing(8'd255, 8'd0, 10'd0, 10'd0);
    random_items(50);
    set_timing(8'd0, 8'd255, 10'd1023, 10'd1023);
    random_items(40);
    set_timing(8'($urandom), 8'($urandom), 10'($urandom_range(1, 1022)),
               10'($urandom_range(1, 1022)));
    random_items(50);
    set_timing(8'($urandom), 8'($urandom), 10'd1, 10'd1);
    random_items(50);

    drain();
    repeat (30) @(negedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/wbfe_pkg.sv
design/wbfe_led_table.sv
design/wbfe_slot_emitter.sv
design/ws2812_blink_frame_encoder_top.sv
design/wbfe_checker.sv
verif/wbfe_checker.sv
verif/tb_top.sv
